[rtl/a32fr_pkg.sv]
package a32fr_pkg;

    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [7:0]  END_MARK  = 8'hCF;
    localparam logic [1:0]  SUM_LAST  = 2'd3;

    typedef enum logic [5:0] {
        PH_LEAD = 6'b000001,
        PH_CMD  = 6'b000010,
        PH_LEN  = 6'b000100,
        PH_DATA = 6'b001000,
        PH_SUM  = 6'b010000,
        PH_END  = 6'b100000
    } t_phase;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_REPORT = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [7:0]  command;
        logic [7:0]  data_length;
        logic [31:0] computed_sum;
        logic [31:0] received_sum;
        logic        complete;
        logic        valid_res;
    } t_result;

endpackage

[rtl/adler32_framed_command_receiver.sv]
// An accepted word that yields a result passes through the input register and then the result register.
// Throughput: one word per cycle; a stalled result holds the result register and,
// behind it, the input register.
// Reset: synchronous active-low i_rst_n empties both registers and returns the frame
// tracker to waiting for a lead word with sums at their initial values.
module adler32_framed_command_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_command,
    output logic [7:0]  o_data_length,
    output logic [31:0] o_computed_sum,
    output logic [31:0] o_received_sum,
    output logic        o_complete,
    output logic        o_valid_res
);
    import a32fr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic    out_free, advance, res_valid;
    t_result res;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    a32fr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_byte     (r_in_byte),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_data_byte    = r_out.data_byte;
    assign o_command      = r_out.command;
    assign o_data_length  = r_out.data_length;
    assign o_computed_sum = r_out.computed_sum;
    assign o_received_sum = r_out.received_sum;
    assign o_complete     = r_out.complete;
    assign o_valid_res    = r_out.valid_res;

endmodule

[rtl/a32fr_core.sv]
module a32fr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output a32fr_pkg::t_result o_res
);
    import a32fr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_command, n_command;
    logic [7:0]  r_length, n_length;
    logic [15:0] r_sum_low, n_sum_low;
    logic [15:0] r_sum_high, n_sum_high;
    logic [31:0] r_checksum, n_checksum;

    logic [16:0] low_raw, low_mod, high_raw, high_mod;
    logic [7:0]  count_inc;
    logic        complete;
    logic [31:0] computed;

    always_comb begin
        low_raw  = {1'b0, r_sum_low} + {9'd0, i_byte};
        low_mod  = (low_raw >= ADLER_MOD) ? low_raw - ADLER_MOD : low_raw;
        high_raw = {1'b0, r_sum_high} + low_mod;
        high_mod = (high_raw >= ADLER_MOD) ? high_raw - ADLER_MOD : high_raw;
        count_inc = r_count + 8'd1;
        complete = (i_byte == END_MARK);
        computed = complete ? {r_sum_high, r_sum_low} : 32'hFFFF_FFFF;
    end

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_command  = r_command;
        n_length   = r_length;
        n_sum_low  = r_sum_low;
        n_sum_high = r_sum_high;
        n_checksum = r_checksum;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_LEAD: begin
                n_sum_low  = 16'd1;
                n_sum_high = 16'd0;
                n_count    = 8'd0;
                n_checksum = 32'd0;
                n_phase    = PH_CMD;
            end
            PH_CMD: begin
                n_command = i_byte;
                n_phase   = PH_LEN;
            end
            PH_LEN: begin
                n_length = i_byte;
                n_count  = 8'd0;
                n_phase  = (i_byte == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                n_sum_low  = low_mod[15:0];
                n_sum_high = high_mod[15:0];
                n_count    = count_inc;
                if (count_inc == r_length) begin
                    n_count = 8'd0;
                    n_phase = PH_SUM;
                end
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_DATA;
                o_res.data_byte = i_byte;
            end
            PH_SUM: begin
                n_checksum = r_checksum | ({24'd0, i_byte} << {r_count[1:0], 3'b000});
                n_count    = count_inc;
                if (r_count[1:0] == SUM_LAST) begin
                    n_count = 8'd0;
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_REPORT;
                o_res.command      = r_command;
                o_res.data_length  = r_length;
                o_res.computed_sum = computed;
                o_res.received_sum = r_checksum;
                o_res.complete     = complete;
                o_res.valid_res    = complete && (computed == r_checksum);
                n_count = 8'd0;
                n_phase = PH_LEAD;
            end
            default: begin
                n_phase = PH_LEAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEAD;
            r_count    <= 8'd0;
            r_command  <= 8'd0;
            r_length   <= 8'd0;
            r_sum_low  <= 16'd1;
            r_sum_high <= 16'd0;
            r_checksum <= 32'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_command  <= n_command;
            r_length   <= n_length;
            r_sum_low  <= n_sum_low;
            r_sum_high <= n_sum_high;
            r_checksum <= n_checksum;
        end
    end

endmodule
